// ----- hdl/lsni_pkg.sv -----
package lsni_pkg;

    localparam int CW         = 10;  // coordinate width
    localparam int OUTW       = 20;  // node_id and site_slot width
    localparam int VOLW       = 21;  // node volume width
    localparam int CFGW       = 6;   // configuration data width
    localparam int CIW        = 4;   // configuration index width
    localparam int NAX        = 4;   // lattice axes
    localparam int DIV_STEPS  = 2;   // quotient bits per divider stage
    localparam int DIV_STAGES = CW / DIV_STEPS;

    localparam logic [CIW-1:0] REG_SUB_X  = CIW'(0);
    localparam logic [CIW-1:0] REG_SUB_Y  = CIW'(1);
    localparam logic [CIW-1:0] REG_SUB_Z  = CIW'(2);
    localparam logic [CIW-1:0] REG_SUB_T  = CIW'(3);
    localparam logic [CIW-1:0] REG_GRID_X = CIW'(4);
    localparam logic [CIW-1:0] REG_GRID_Y = CIW'(5);
    localparam logic [CIW-1:0] REG_GRID_Z = CIW'(6);
    localparam logic [CIW-1:0] REG_GRID_T = CIW'(7);

endpackage

// ----- hdl/lattice_site_to_node_index.sv -----
// The pipeline has 5 divider stages, 3 multiply stages and 1 output
// stage.
// Throughput: one item per cycle; the whole pipeline holds when the result
// register is full and m_ready is low.
// Reset (aresetn, synchronous, active low) empties the pipeline and loads
// sub sizes 1,1,1,2 and grid sizes 1,1,1,1.
module lattice_site_to_node_index
    import lsni_pkg::*;
#(
    parameter int MAX_SUB_SIZE  = 32,
    parameter int MAX_GRID_SIZE = 32
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [CIW-1:0]  cfg_index,
    input  logic [CFGW-1:0] cfg_data,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic [CW-1:0]   s_coord_x,
    input  logic [CW-1:0]   s_coord_y,
    input  logic [CW-1:0]   s_coord_z,
    input  logic [CW-1:0]   s_coord_t,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [OUTW-1:0] m_node_id,
    output logic [OUTW-1:0] m_site_slot,
    output logic            m_odd_site,
    output logic            m_out_of_range
);

    localparam int SW  = $clog2(MAX_SUB_SIZE + 1);
    localparam int GW  = $clog2(MAX_GRID_SIZE + 1);
    localparam int NST = DIV_STAGES + 4;

    // configuration
    logic [SW-1:0] sub_reg  [NAX];
    logic [GW-1:0] grid_reg [NAX];
    logic [SW-1:0] sub_wr;
    logic [GW-1:0] grid_wr;

    always_comb begin
        if (cfg_data == '0) begin
            sub_wr  = SW'(1);
            grid_wr = GW'(1);
        end else begin
            if (32'(cfg_data) > 32'(MAX_SUB_SIZE)) sub_wr = SW'(MAX_SUB_SIZE);
            else sub_wr = SW'(cfg_data);
            if (32'(cfg_data) > 32'(MAX_GRID_SIZE)) grid_wr = GW'(MAX_GRID_SIZE);
            else grid_wr = GW'(cfg_data);
        end
    end

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sub_reg[0]  <= SW'(1);
            sub_reg[1]  <= SW'(1);
            sub_reg[2]  <= SW'(1);
            sub_reg[3]  <= SW'(2);
            grid_reg[0] <= GW'(1);
            grid_reg[1] <= GW'(1);
            grid_reg[2] <= GW'(1);
            grid_reg[3] <= GW'(1);
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_SUB_X:  sub_reg[0]  <= sub_wr;
                REG_SUB_Y:  sub_reg[1]  <= sub_wr;
                REG_SUB_Z:  sub_reg[2]  <= sub_wr;
                REG_SUB_T:  sub_reg[3]  <= sub_wr;
                REG_GRID_X: grid_reg[0] <= grid_wr;
                REG_GRID_Y: grid_reg[1] <= grid_wr;
                REG_GRID_Z: grid_reg[2] <= grid_wr;
                REG_GRID_T: grid_reg[3] <= grid_wr;
                default: ;
            endcase
        end
    end

    // pipeline control
    logic           adv;
    logic [NST-1:0] v_reg;
    logic [NST-1:0] oor_reg;
    logic [NST-1:0] odd_reg;
    logic           oor_next;
    logic           odd_next;
    logic [CW-1:0]  s_coord [NAX];

    assign adv     = !v_reg[NST-1] || m_ready;
    assign s_ready = adv;
    assign m_valid = v_reg[NST-1];

    assign s_coord[0] = s_coord_x;
    assign s_coord[1] = s_coord_y;
    assign s_coord[2] = s_coord_z;
    assign s_coord[3] = s_coord_t;

    always_comb begin
        oor_next = 1'b0;
        for (int a = 0; a < NAX; a++) begin
            if ((SW + GW + CW)'(s_coord[a]) >=
                (SW + GW + CW)'(sub_reg[a]) * (SW + GW + CW)'(grid_reg[a]))
                oor_next = 1'b1;
        end
        odd_next = s_coord[0][0] ^ s_coord[1][0] ^ s_coord[2][0] ^ s_coord[3][0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (adv) begin
            v_reg <= {v_reg[NST-2:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            oor_reg <= {oor_reg[NST-2:0], oor_next};
            odd_reg <= {odd_reg[NST-2:0], odd_next};
        end
    end

    // restoring divider, DIV_STEPS quotient bits per stage
    function automatic logic [SW+CW-1:0] div_step(
        input logic [SW-1:0] rem,
        input logic [CW-1:0] work,
        input logic [SW-1:0] d
    );
        logic [SW:0] trial;
        logic        qbit;
        trial = {rem, work[CW-1]};
        qbit  = 1'b0;
        if (trial >= {1'b0, d}) begin
            trial = trial - {1'b0, d};
            qbit  = 1'b1;
        end
        return {trial[SW-1:0], work[CW-2:0], qbit};
    endfunction

    logic [SW-1:0] dv_rem_reg   [DIV_STAGES][NAX];
    logic [CW-1:0] dv_work_reg  [DIV_STAGES][NAX];
    logic [SW-1:0] dv_rem_next  [DIV_STAGES][NAX];
    logic [CW-1:0] dv_work_next [DIV_STAGES][NAX];

    always_comb begin
        logic [SW+CW-1:0] st;
        for (int a = 0; a < NAX; a++) begin
            st = {{SW{1'b0}}, s_coord[a]};
            for (int j = 0; j < DIV_STEPS; j++)
                st = div_step(st[SW+CW-1:CW], st[CW-1:0], sub_reg[a]);
            dv_rem_next[0][a]  = st[SW+CW-1:CW];
            dv_work_next[0][a] = st[CW-1:0];
        end
        for (int k = 1; k < DIV_STAGES; k++) begin
            for (int a = 0; a < NAX; a++) begin
                st = {dv_rem_reg[k-1][a], dv_work_reg[k-1][a]};
                for (int j = 0; j < DIV_STEPS; j++)
                    st = div_step(st[SW+CW-1:CW], st[CW-1:0], sub_reg[a]);
                dv_rem_next[k][a]  = st[SW+CW-1:CW];
                dv_work_next[k][a] = st[CW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dv_rem_reg  <= dv_rem_next;
            dv_work_reg <= dv_work_next;
        end
    end

    // quotients and remainders after the last divider stage
    logic [CW-1:0] q [NAX];
    logic [SW-1:0] r [NAX];

    always_comb begin
        for (int a = 0; a < NAX; a++) begin
            q[a] = dv_work_reg[DIV_STAGES-1][a];
            r[a] = dv_rem_reg[DIV_STAGES-1][a];
        end
    end

    // Horner chains for node and index, volume product alongside
    logic [CW-1:0]   m1_q0_reg, m1_q1_reg;
    logic [SW-1:0]   m1_r0_reg, m1_r1_reg;
    logic [OUTW-1:0] m1_a_reg;
    logic [VOLW-1:0] m1_b_reg, m1_vp1_reg, m1_vp2_reg;
    logic [CW-1:0]   m2_q0_reg;
    logic [SW-1:0]   m2_r0_reg;
    logic [OUTW-1:0] m2_a_reg;
    logic [VOLW-1:0] m2_b_reg, m2_vol_reg;
    logic [OUTW-1:0] m3_node_reg;
    logic [VOLW-1:0] m3_idx_reg, m3_vol_reg;
    logic [OUTW-1:0] out_node_reg, out_slot_reg;
    logic            out_odd_reg, out_oor_reg;
    logic [VOLW-1:0] slot_sum;

    always_ff @(posedge aclk) begin
        if (adv) begin
            m1_q0_reg  <= q[0];
            m1_q1_reg  <= q[1];
            m1_r0_reg  <= r[0];
            m1_r1_reg  <= r[1];
            m1_a_reg   <= OUTW'(q[2]) + OUTW'(grid_reg[2]) * OUTW'(q[3]);
            m1_b_reg   <= VOLW'(r[2]) + VOLW'(sub_reg[2]) * VOLW'(r[3]);
            m1_vp1_reg <= VOLW'(sub_reg[0]) * VOLW'(sub_reg[1]);
            m1_vp2_reg <= VOLW'(sub_reg[2]) * VOLW'(sub_reg[3]);

            m2_q0_reg  <= m1_q0_reg;
            m2_r0_reg  <= m1_r0_reg;
            m2_a_reg   <= OUTW'(m1_q1_reg) + OUTW'(grid_reg[1]) * m1_a_reg;
            m2_b_reg   <= VOLW'(m1_r1_reg) + VOLW'(sub_reg[1]) * m1_b_reg;
            m2_vol_reg <= m1_vp1_reg * m1_vp2_reg;

            m3_node_reg <= OUTW'(m2_q0_reg) + OUTW'(grid_reg[0]) * m2_a_reg;
            m3_idx_reg  <= VOLW'(m2_r0_reg) + VOLW'(sub_reg[0]) * m2_b_reg;
            m3_vol_reg  <= m2_vol_reg;
        end
    end

    // odd sites go to the upper half of the node's slots
    assign slot_sum = odd_reg[NST-2] ? m3_idx_reg + m3_vol_reg : m3_idx_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_oor_reg <= oor_reg[NST-2];
            if (oor_reg[NST-2]) begin
                out_node_reg <= '0;
                out_slot_reg <= '0;
                out_odd_reg  <= 1'b0;
            end else begin
                out_node_reg <= m3_node_reg;
                out_slot_reg <= slot_sum[VOLW-1:1];
                out_odd_reg  <= odd_reg[NST-2];
            end
        end
    end

    assign m_node_id      = out_node_reg;
    assign m_site_slot    = out_slot_reg;
    assign m_odd_site     = out_odd_reg;
    assign m_out_of_range = out_oor_reg;

endmodule
